// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl files
// expects clk_i and rst_ni in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppdr_pkg
// shared constants, types and tables of the planar pose dead reckoning block
// ----------------------------------------------------------------------------
package ppdr_pkg;

  localparam int unsigned ANGLE_WIDTH = 32;
  localparam int unsigned HEAD_PAD    = 64 - ANGLE_WIDTH;
  localparam int unsigned CORD_AW     = 18;
  localparam int unsigned CORD_ITERS  = 16;
  localparam int unsigned ITER_W      = $clog2(CORD_ITERS);
  localparam int unsigned MUL_W       = 32;

  // 2^64 / (2 pi 1e9), turns per nanoradian scaled
  localparam logic [MUL_W-1:0] TURN_SCALE = 32'd2935890503;
  // 2^30 / cordic gain
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef logic signed [15:0] q15_t;

  typedef struct packed {
    logic               start;
    logic [CORD_AW-1:0] angle;
  } cord_req_t;

  typedef struct packed {
    logic done;
    q15_t sine;
    q15_t cosine;
  } cord_res_t;

  // arctangent of 2^-i in units of 2^-18 turn
  function automatic logic [16:0] atan_step(input logic [ITER_W-1:0] i);
    logic [16:0] r;
    unique case (i)
      4'd0:    r = 17'd32768;
      4'd1:    r = 17'd19344;
      4'd2:    r = 17'd10221;
      4'd3:    r = 17'd5188;
      4'd4:    r = 17'd2604;
      4'd5:    r = 17'd1303;
      4'd6:    r = 17'd652;
      4'd7:    r = 17'd326;
      4'd8:    r = 17'd163;
      4'd9:    r = 17'd81;
      4'd10:   r = 17'd41;
      4'd11:   r = 17'd20;
      4'd12:   r = 17'd10;
      4'd13:   r = 17'd5;
      4'd14:   r = 17'd3;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/ppdr_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppdr_mul
// shared unsigned 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module ppdr_mul (
  input  wire logic                          clk_i,
  input  wire logic [ppdr_pkg::MUL_W-1:0]    a_i,
  input  wire logic [ppdr_pkg::MUL_W-1:0]    b_i,
  output logic      [2*ppdr_pkg::MUL_W-1:0]  prod_o
);
  import ppdr_pkg::*;

  logic [2*MUL_W-1:0] prod_d;
  logic [2*MUL_W-1:0] prod_q;

  assign prod_d = (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== src/ppdr_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppdr_cordic
// iterative rotation-mode cordic, one micro-rotation per cycle, q1.15 out
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ppdr_cordic (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  ppdr_pkg::cord_req_t       req_i,
  output ppdr_pkg::cord_res_t       res_o
);
  import ppdr_pkg::*;

  localparam int unsigned XW = 34;
  localparam int unsigned ZW = 20;
  localparam int unsigned RW = XW - 14;

  localparam logic signed [ZW-1:0]   QUARTER   = 20'sd65536;
  localparam logic signed [ZW-1:0]   HALF      = 20'sd131072;
  localparam logic signed [XW:0]     Q15_HALF  = 35'sd16384;
  localparam logic signed [RW-1:0]   Q15_MAX   = 20'sd32767;
  localparam logic signed [RW-1:0]   Q15_MIN   = -20'sd32768;
  localparam logic [ITER_W-1:0]      LAST_ITER = ITER_W'(CORD_ITERS - 1);

  logic signed [XW-1:0] x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [ITER_W-1:0]    iter_q;
  logic                 busy_q, fin_q, done_q, flip_q;
  q15_t                 sine_q, cosine_q;

  logic signed [ZW-1:0] z_in, z_red;
  logic                 flip_in;
  logic signed [XW-1:0] xs, ys, xf, yf;
  logic signed [ZW-1:0] at;

  function automatic q15_t to_q15(input logic signed [XW-1:0] v);
    logic signed [XW:0]   t;
    logic signed [RW-1:0] r;
    t = (XW+1)'(v) + Q15_HALF;
    r = RW'(t >>> 15);
    if (r > Q15_MAX) begin
      r = Q15_MAX;
    end else if (r < Q15_MIN) begin
      r = Q15_MIN;
    end
    return 16'(r);
  endfunction

  // quadrant reduction by a half turn
  always_comb begin
    z_in    = ZW'(signed'(req_i.angle));
    z_red   = z_in;
    flip_in = 1'b0;
    if (z_in > QUARTER) begin
      z_red   = z_in - HALF;
      flip_in = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_red   = z_in + HALF;
      flip_in = 1'b1;
    end
  end

  // micro-rotation
  always_comb begin
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    at = signed'(ZW'(atan_step(iter_q)));
    if (!z_q[ZW-1]) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  assign xf = flip_q ? -x_q : x_q;
  assign yf = flip_q ? -y_q : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= fin_q;
      if (req_i.start) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == LAST_ITER) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= CORDIC_X0;
      y_q    <= '0;
      z_q    <= z_red;
      flip_q <= flip_in;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
    if (fin_q) begin
      sine_q   <= to_q15(yf);
      cosine_q <= to_q15(xf);
    end
  end

  assign res_o.done   = done_q;
  assign res_o.sine   = sine_q;
  assign res_o.cosine = cosine_q;

  `ASSERT_NEXT(a_start_runs, req_i.start, busy_q && iter_q == '0 && !fin_q, "start not taken")
  `ASSERT_NEXT(a_last_iter_fin, busy_q && iter_q == LAST_ITER && !req_i.start,
               fin_q && !busy_q, "rotation did not finish after last step")
  `ASSERT_IMPL(a_fin_not_busy, fin_q, !busy_q, "finish and rotation overlap")

endmodule
`default_nettype wire

// ===== src/planar_pose_dead_reckoning_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_pose_dead_reckoning_top
// unicycle dead reckoning: heading, saturating x/y in nm and yaw quaternion
// ----------------------------------------------------------------------------
// One transaction is taken, then in_stall_o stays high while a
// small sequencer runs it through one shared 32x32 multiplier and one
// iterative cordic: four multiplier steps for the heading increment, a
// 16-step cordic pass for the sine and cosine of the new heading, three
// multiplier steps per axis for the position, and a second 16-step cordic
// pass for the half-heading quaternion. A new transaction is only taken once
// the sequencer has loaded the last result. The result sits in an output
// register, so the next transaction is taken while a result still waits on
// out_stall_i.
`include "assert_macros.svh"
module planar_pose_dead_reckoning_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] linear_speed_i,
  input  wire logic signed [15:0] yaw_rate_i,
  input  wire logic        [31:0] timestamp_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [47:0] pos_x_o,
  output logic signed      [47:0] pos_y_o,
  output logic             [15:0] heading_o,
  output logic signed      [15:0] quat_z_o,
  output logic signed      [15:0] quat_w_o
);
  import ppdr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MW   = 4'd1;
  localparam logic [3:0] S_MLO  = 4'd2;
  localparam logic [3:0] S_MHI  = 4'd3;
  localparam logic [3:0] S_HEAD = 4'd4;
  localparam logic [3:0] S_CS1  = 4'd5;
  localparam logic [3:0] S_CW1  = 4'd6;
  localparam logic [3:0] S_PM1  = 4'd7;
  localparam logic [3:0] S_PM2  = 4'd8;
  localparam logic [3:0] S_PM3  = 4'd9;
  localparam logic [3:0] S_CS2  = 4'd10;
  localparam logic [3:0] S_CW2  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] POS_MIN = 48'h8000_0000_0000;
  localparam logic [63:0] RND_HALF = 64'd16384;

  logic [3:0] state_q, state_d;

  logic [31:0]            dt_q, last_ts_q;
  logic [15:0]            vabs_q, wabs_q, mhi_q;
  logic                   vneg_q, wneg_q, neg_q, axis_q;
  logic [63:0]            acc_q;
  logic [ANGLE_WIDTH-1:0] heading_q;
  logic [47:0]            pose_x_q, pose_y_q;

  logic                   out_valid_q;
  logic [47:0]            out_x_q, out_y_q;
  logic [15:0]            out_head_q;
  q15_t                   out_qz_q, out_qw_q;

  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [2*MUL_W-1:0]     prod;
  cord_req_t              cord_req;
  cord_res_t              cord_res;

  logic [63:0]            head_ext, p64, rnd;
  logic [ANGLE_WIDTH-1:0] inc;
  q15_t                   trig;
  logic [47:0]            delta, pose_sel, pose_new;
  logic [48:0]            sum49;
  logic                   in_take, out_take, out_load;

  function automatic logic [15:0] mag16(input logic [15:0] a);
    return a[15] ? (~a + 16'd1) : a;
  endfunction

  ppdr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ppdr_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cord_req),
    .res_o  (cord_res)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign head_ext = {heading_q, {HEAD_PAD{1'b0}}};
  assign p64      = acc_q + {prod[31:0], 32'd0};
  assign inc      = p64[63 -: ANGLE_WIDTH];

  // position step: rounded product, signed add, clamp to 48 bits
  assign trig     = axis_q ? cord_res.sine : cord_res.cosine;
  assign rnd      = prod + RND_HALF;
  assign delta    = rnd[62:15];
  assign pose_sel = axis_q ? pose_y_q : pose_x_q;
  assign sum49    = neg_q ? ({pose_sel[47], pose_sel} - {1'b0, delta})
                          : ({pose_sel[47], pose_sel} + {1'b0, delta});
  assign pose_new = (sum49[48] != sum49[47]) ? (sum49[48] ? POS_MIN : POS_MAX)
                                             : sum49[47:0];

  always_comb begin
    mul_a          = '0;
    mul_b          = '0;
    cord_req.start = 1'b0;
    cord_req.angle = head_ext[63 -: CORD_AW];
    state_d        = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_MW;
        end
      end
      S_MW: begin
        mul_a   = {16'd0, wabs_q};
        mul_b   = dt_q;
        state_d = S_MLO;
      end
      S_MLO: begin
        mul_a   = prod[31:0];
        mul_b   = TURN_SCALE;
        state_d = S_MHI;
      end
      S_MHI: begin
        mul_a   = {16'd0, mhi_q};
        mul_b   = TURN_SCALE;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        state_d = S_CS1;
      end
      S_CS1: begin
        cord_req.start = 1'b1;
        state_d        = S_CW1;
      end
      S_CW1: begin
        if (cord_res.done) begin
          state_d = S_PM1;
        end
      end
      S_PM1: begin
        mul_a   = {16'd0, vabs_q};
        mul_b   = {16'd0, mag16(trig)};
        state_d = S_PM2;
      end
      S_PM2: begin
        mul_a   = prod[31:0];
        mul_b   = dt_q;
        state_d = S_PM3;
      end
      S_PM3: begin
        state_d = axis_q ? S_CS2 : S_PM1;
      end
      S_CS2: begin
        cord_req.start = 1'b1;
        cord_req.angle = {1'b0, head_ext[63 -: CORD_AW-1]};
        state_d        = S_CW2;
      end
      S_CW2: begin
        if (cord_res.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_ts_q   <= '0;
      heading_q   <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        last_ts_q <= timestamp_us_i;
      end
      if (state_q == S_HEAD) begin
        heading_q <= wneg_q ? (heading_q - inc) : (heading_q + inc);
      end
      if (state_q == S_CW1) begin
        axis_q <= 1'b0;
      end
      if (state_q == S_PM3) begin
        if (axis_q) begin
          pose_y_q <= pose_new;
        end else begin
          pose_x_q <= pose_new;
        end
        axis_q <= ~axis_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      dt_q   <= timestamp_us_i - last_ts_q;
      vabs_q <= mag16(linear_speed_i);
      wabs_q <= mag16(yaw_rate_i);
      vneg_q <= linear_speed_i[15];
      wneg_q <= yaw_rate_i[15];
    end
    if (state_q == S_MLO) begin
      mhi_q <= prod[47:32];
    end
    if (state_q == S_MHI) begin
      acc_q <= prod;
    end
    if (state_q == S_PM1) begin
      neg_q <= vneg_q ^ trig[15];
    end
    if (out_load) begin
      out_x_q    <= pose_x_q;
      out_y_q    <= pose_y_q;
      out_head_q <= head_ext[63 -: 16];
      out_qz_q   <= cord_res.sine;
      out_qw_q   <= cord_res.cosine;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign heading_o   = out_head_q;
  assign quat_z_o    = out_qz_q;
  assign quat_w_o    = out_qw_q;

  `ASSERT_NEXT(a_accept_starts, in_take, state_q == S_MW, "accepted transaction not started")
  `ASSERT_NEXT(a_result_held, state_q == S_OUT && out_valid_q && out_stall_i,
               state_q == S_OUT && out_valid_q, "finished result dropped while output busy")
  `ASSERT_IMPL(a_cord_done_waited, cord_res.done, state_q == S_CW1 || state_q == S_CW2,
               "cordic finished outside a wait state")

endmodule
`default_nettype wire

// ===== bench/pose_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_checker
// watches both channels of the dead reckoning block, predicts the pose report
// of every accepted sample and compares each delivered report field by field
// ----------------------------------------------------------------------------
module pose_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] linear_speed_i,
  input  logic signed [15:0] yaw_rate_i,
  input  logic        [31:0] timestamp_us_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [47:0] pos_x_i,
  input  logic signed [47:0] pos_y_i,
  input  logic        [15:0] heading_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output int                 error_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  import ppdr_pkg::q15_t;

  localparam logic [31:0] TURNS_PER_NRAD = 32'd2935890503;
  localparam longint      CORDIC_START   = 652032874;
  localparam longint      POS_MAX        = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      POS_MIN        = -POS_MAX - 1;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic        [15:0] heading;
    q15_t               qz;
    q15_t               qw;
  } pose_report_t;

  logic signed [47:0] est_x;
  logic signed [47:0] est_y;
  logic        [31:0] est_angle;
  logic        [31:0] last_ts;
  pose_report_t       pose_q[$];

  // arctangent of 2^-i in 2^-18 turn
  function automatic longint atan_turn(input int i);
    case (i)
      0:       return 32768;
      1:       return 19344;
      2:       return 10221;
      3:       return 5188;
      4:       return 2604;
      5:       return 1303;
      6:       return 652;
      7:       return 326;
      8:       return 163;
      9:       return 81;
      10:      return 41;
      11:      return 20;
      12:      return 10;
      13:      return 5;
      14:      return 3;
      default: return 1;
    endcase
  endfunction

  function automatic longint unsigned mag16(input logic signed [15:0] v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic q15_t to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return q15_t'(r);
  endfunction

  function automatic void cordic_sincos(input logic [17:0] ang, output q15_t sin_q,
                                        output q15_t cos_q);
    longint z, x, y, xn, yn;
    logic   flip;
    int     i;
    z    = ang;
    x    = CORDIC_START;
    y    = 0;
    flip = 1'b0;
    if (z >= 131072) z -= 262144;
    if (z > 65536) begin
      z -= 131072;
      flip = 1'b1;
    end else if (z < -65536) begin
      z += 131072;
      flip = 1'b1;
    end
    for (i = 0; i < 16; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        yn = y + (x >>> i);
        z -= atan_turn(i);
      end else begin
        xn = x + (y >>> i);
        yn = y - (x >>> i);
        z += atan_turn(i);
      end
      x = xn;
      y = yn;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sin_q = to_q15(y);
    cos_q = to_q15(x);
  endfunction

  // rounded step along one axis, clamped to the 48 bit range
  function automatic logic signed [47:0] move_axis(input logic signed [47:0] p,
                                                   input longint unsigned travel,
                                                   input logic reverse, input q15_t t);
    longint unsigned d;
    longint          r;
    d = (travel * mag16(t) + 64'd16384) >> 15;
    if (reverse != (t < 0)) r = longint'(p) - longint'(d);
    else r = longint'(p) + longint'(d);
    if (r > POS_MAX) r = POS_MAX;
    if (r < POS_MIN) r = POS_MIN;
    return r[47:0];
  endfunction

  function automatic pose_report_t advance_pose(input logic signed [15:0] spd,
                                                input logic signed [15:0] yaw,
                                                input logic [31:0] ts);
    pose_report_t    r;
    logic [31:0]     dt;
    logic [127:0]    turn_prod;
    longint unsigned travel;
    q15_t            s, c;
    dt        = ts - last_ts;
    last_ts   = ts;
    turn_prod = 128'(mag16(yaw) * 64'(dt)) * 128'(TURNS_PER_NRAD);
    if (yaw < 0) est_angle = est_angle - turn_prod[63:32];
    else est_angle = est_angle + turn_prod[63:32];
    cordic_sincos(est_angle[31:14], s, c);
    travel    = mag16(spd) * 64'(dt);
    est_x     = move_axis(est_x, travel, spd < 0, c);
    est_y     = move_axis(est_y, travel, spd < 0, s);
    r.x       = est_x;
    r.y       = est_y;
    r.heading = est_angle[31:16];
    // half heading lies in the first half turn
    cordic_sincos({1'b0, est_angle[31:15]}, r.qz, r.qw);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_report_t want;
    if (!rst_ni) begin
      est_x         = '0;
      est_y         = '0;
      est_angle     = '0;
      last_ts       = '0;
      pose_q.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pose_q.size() == 0) begin
          $display("%0t: pose report with no transaction pending, got x %0d y %0d",
                   $time, pos_x_i, pos_y_i);
          error_count_o++;
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x", want.x, pos_x_i);
          check_field("pos_y", want.y, pos_y_i);
          check_field("heading", want.heading, heading_i);
          check_field("quat_z", want.qz, quat_z_i);
          check_field("quat_w", want.qw, quat_w_i);
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pose_q.push_back(advance_pose(linear_speed_i, yaw_rate_i, timestamp_us_i));
      end
      pending_o = pose_q.size();
    end
  end

endmodule

// ===== bench/planar_pose_dead_reckoning_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_dead_reckoning_top_tb
// drives velocity samples into the dead reckoning block with random gaps and
// back-pressure; a checker beside the block predicts and compares each pose
// ----------------------------------------------------------------------------
module planar_pose_dead_reckoning_top_tb;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_SAMPLES = 400;
  localparam int DRAIN_CYCLES   = 100;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] linear_speed;
  logic signed [15:0] yaw_rate;
  logic        [31:0] timestamp_us;
  logic               out_valid;
  logic               out_stall;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic        [15:0] heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  int                 error_count;
  int                 pending;
  int                 checked;
  int                 driven;
  logic               long_hold;
  bit                 tx_calm;
  logic        [31:0] ts_now;

  planar_pose_dead_reckoning_top u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .linear_speed_i (linear_speed),
    .yaw_rate_i     (yaw_rate),
    .timestamp_us_i (timestamp_us),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .heading_o      (heading),
    .quat_z_o       (quat_z),
    .quat_w_o       (quat_w)
  );

  pose_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .linear_speed_i (linear_speed),
    .yaw_rate_i     (yaw_rate),
    .timestamp_us_i (timestamp_us),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .heading_i      (heading),
    .quat_z_i       (quat_z),
    .quat_w_i       (quat_w),
    .error_count_o  (error_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 70);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic signed [15:0] spd, input logic signed [15:0] yaw,
                             input logic [31:0] ts);
    int gap;
    if ($urandom_range(29) == 0) tx_calm = !tx_calm;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    linear_speed = spd;
    yaw_rate     = yaw;
    timestamp_us = ts;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    driven++;
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : rx_side
    int stall_left;
    bit rx_calm;
    stall_left = 0;
    rx_calm    = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        long_hold = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(39) == 0) rx_calm = !rx_calm;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("planar_pose_dead_reckoning_top_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int                 n;
    int                 kind;
    logic signed [15:0] spd;
    logic signed [15:0] yaw;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    linear_speed = '0;
    yaw_rate     = '0;
    timestamp_us = '0;
    long_hold    = 1'b0;
    tx_calm      = 1'b0;
    driven       = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed
    send_sample(16'sd0, 16'sd0, 32'd0);
    send_sample(16'sd1000, 16'sd0, 32'd1_000_000);
    send_sample(16'sd1000, 16'sd1571, 32'd2_000_000);
    send_sample(-16'sd1000, -16'sd3142, 32'd3_000_000);
    send_sample(16'sd0, 16'sd500, 32'd3_500_000);
    send_sample(16'sh7FFF, 16'sh7FFF, 32'd3_500_001);
    send_sample(16'sh8000, 16'sh8000, 32'd3_750_000);
    send_sample(16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF);
    send_sample(16'sh8000, 16'sh7FFF, 32'd5);
    send_sample(16'sd1, -16'sd1, 32'd4);
    ts_now = 32'd4;
    repeat (3) begin
      ts_now += 32'hFFFF_FFF0;
      send_sample(16'sh7FFF, 16'sd0, ts_now);
    end
    repeat (4) begin
      ts_now += 32'hFFFF_FFF0;
      send_sample(16'sh8000, 16'sd0, ts_now);
    end
    ts_now += 32'd1000;
    send_sample(16'sh8000, 16'sh7FFF, ts_now);
    send_sample(16'sh7FFF, 16'sh8000, ts_now);
    wait_for_results();

    // random
    for (n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n == 120) long_hold = 1'b1;
      if (n == 260) wait_for_results();
      kind = $urandom_range(99);
      spd  = 16'($urandom);
      yaw  = 16'($urandom);
      if (kind < 80) begin
        ts_now += $urandom_range(1, 250_000);
      end else if (kind < 88) begin
        ts_now += $urandom_range(0, 20);
      end else if (kind < 95) begin
        spd    = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        yaw    = $urandom_range(2) == 0 ? 16'sd0 : ($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
        ts_now += $urandom_range(1, 1_000_000);
      end else begin
        ts_now = $urandom;
      end
      send_sample(spd, yaw, ts_now);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("%0d samples sent, %0d pose reports compared", driven, checked);
    $display("included zero and wrapped time steps, full-scale rates, clamped positions,");
    $display("a %0d-cycle output hold and a pause for the pipeline to empty", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("planar_pose_dead_reckoning_top_tb: clean");
    end else begin
      $display("planar_pose_dead_reckoning_top_tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ppdr_pkg.sv
src/ppdr_mul.sv
src/ppdr_cordic.sv
src/planar_pose_dead_reckoning_top.sv
bench/pose_checker.sv
bench/planar_pose_dead_reckoning_top_tb.sv
